// ===== src/sms_pkg.sv =====
// shared types and constants for the sorted matrix search block
`timescale 1ns / 1ps
package sms_pkg;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  // configuration register indexes
  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  // widths fixed by the interface
  localparam int VALUE_W = 32;
  localparam int POS_W   = 4;
  localparam int SIZE_W  = 5;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  // search request handed to the walker
  typedef struct packed {
    logic                      start;
    logic signed [VALUE_W-1:0] key;
  } search_req_t;

  // one search result
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
  } hit_t;

endpackage

// ===== src/sorted_matrix_search.sv =====
// Staircase search over a matrix with ascending rows and columns.
//
// Channels: item_* takes loads and searches; kind selects which. A load
// writes entry_value at entry_row, entry_col and gives no result; rows or
// columns beyond the store are dropped. A search walks from the top-right
// entry of the region in use, down on a larger key, left on a smaller one,
// and gives one transfer on result_* with found, hit_row and hit_col
// (zeros when the walk leaves the region). cfg_* writes rows_in_use
// (index 0) and cols_in_use (index 1) and is always ready.
// Flow: a search does one memory read and compare per cycle while it walks,
// reading from the registered read port of the ram, and the item channel
// takes no load or search until the walk is done. The item channel is
// ready again once the result sits in the output register; item_ready
// follows the idle state of the walker.
// Reset clears control state and sets both sizes to 16; matrix contents
// stay undefined until loaded. A stalled result receiver holds the result
// register; loads are still taken, and a following search waits at its end.
`timescale 1ns / 1ps
module sorted_matrix_search #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic                                kind,
  input  logic [sms_pkg::POS_W-1:0]           entry_row,
  input  logic [sms_pkg::POS_W-1:0]           entry_col,
  input  logic signed [sms_pkg::VALUE_W-1:0]  entry_value,
  input  logic signed [sms_pkg::VALUE_W-1:0]  search_key,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                found,
  output logic [sms_pkg::POS_W-1:0]           hit_row,
  output logic [sms_pkg::POS_W-1:0]           hit_col,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [sms_pkg::SIZE_W-1:0]          cfg_data
);
  import sms_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

  logic [SIZE_W-1:0] rows_in_use;
  logic [SIZE_W-1:0] cols_in_use;
  logic              item_fire;
  logic              load_en;
  logic [AW-1:0]     wr_addr;
  logic              rd_en;
  logic [AW-1:0]     rd_addr;
  logic [VALUE_W-1:0] rd_data;
  logic              walk_idle;
  search_req_t       req;
  hit_t              res;

  assign cfg_ready  = 1'b1;
  assign item_ready = walk_idle;
  assign item_fire  = item_valid && item_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROWS: rows_in_use <= cfg_data;
        REG_COLS: cols_in_use <= cfg_data;
        default:  ;
      endcase
    end
  end

  // load path straight into the store
  assign load_en = item_fire && (kind == KIND_LOAD)
                   && (9'(entry_row) < 9'(MAX_ROWS))
                   && (9'(entry_col) < 9'(MAX_COLS));
  assign wr_addr = AW'(AW'(entry_row) * AW'(MAX_COLS) + AW'(entry_col));

  // search request
  assign req.start = item_fire && (kind == KIND_SEARCH);
  assign req.key   = search_key;

  sms_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_en),
    .wr_addr (wr_addr),
    .wr_data (entry_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sms_walk #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_walk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rows_in_use (rows_in_use),
    .cols_in_use (cols_in_use),
    .idle        (walk_idle),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .res_valid   (result_valid),
    .res_ready   (result_ready),
    .res         (res)
  );

  assign found   = res.found;
  assign hit_row = res.row;
  assign hit_col = res.col;

endmodule

// ===== src/sms_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps
module sms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/sms_walk.sv =====
// staircase walker: one memory read and one compare per step, result register
`timescale 1ns / 1ps
module sms_walk #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic                                                  clk,
  input  logic                                                  rst,
  input  sms_pkg::search_req_t                                  req,
  input  logic [sms_pkg::SIZE_W-1:0]                            rows_in_use,
  input  logic [sms_pkg::SIZE_W-1:0]                            cols_in_use,
  output logic                                                  idle,
  output logic                                                  rd_en,
  output logic [(MAX_ROWS*MAX_COLS > 1 ? $clog2(MAX_ROWS*MAX_COLS) : 1)-1:0] rd_addr,
  input  logic [sms_pkg::VALUE_W-1:0]                           rd_data,
  output logic                                                  res_valid,
  input  logic                                                  res_ready,
  output sms_pkg::hit_t                                         res
);
  import sms_pkg::*;

  localparam int DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int AW     = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int NR_MAX = MAX_ROWS < 31 ? MAX_ROWS : 31;
  localparam int NC_MAX = MAX_COLS < 31 ? MAX_COLS : 31;
  localparam int NRW    = $clog2(NR_MAX + 1);
  localparam int NCW    = $clog2(NC_MAX + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [NRW-1:0]            row;
  logic [NRW-1:0]            row_next;
  logic [NCW-1:0]            colp;      // column plus one, zero is left of region
  logic [NCW-1:0]            colp_next;
  logic signed [VALUE_W-1:0] key;
  logic [NRW-1:0]            nr;
  logic [NCW-1:0]            nc;
  logic                      in_region;
  logic                      in_region_next;
  logic                      finish;
  logic                      match;
  logic signed [VALUE_W-1:0] entry;
  hit_t                      hold;

  // clamp the region size to the store
  assign nr = (9'(rows_in_use) > 9'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_in_use);
  assign nc = (9'(cols_in_use) > 9'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_in_use);

  assign entry          = $signed(rd_data);
  assign in_region      = (row < nr) && (colp != '0);
  assign in_region_next = (row_next < nr) && (colp_next != '0);
  assign idle           = (state == S_IDLE);

  // step decision and next read address
  always_comb begin
    row_next   = row;
    colp_next  = colp;
    state_next = state;
    finish     = 1'b0;
    match      = 1'b0;
    rd_en      = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req.start) begin
          row_next   = '0;
          colp_next  = nc;
          state_next = S_WALK;
          rd_en      = in_region_next;
        end
      end
      S_WALK: begin
        if (!in_region) begin
          finish = 1'b1;
        end else if (key > entry) begin
          row_next = row + NRW'(1);
        end else if (key < entry) begin
          colp_next = colp - NCW'(1);
        end else begin
          finish = 1'b1;
          match  = 1'b1;
        end
        if (finish) begin
          state_next = S_DONE;
        end
        rd_en = !finish && in_region_next;
      end
      S_DONE: begin
        if (!res_valid || res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign rd_addr = AW'(AW'(row_next) * AW'(MAX_COLS) + AW'(colp_next) - AW'(1));

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!res_valid || res_ready)) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // walk position, key and result payload
  always_ff @(posedge clk) begin
    row  <= row_next;
    colp <= colp_next;
    if (state == S_IDLE && req.start) begin
      key <= req.key;
    end
    if (finish) begin
      hold.found <= match;
      hold.row   <= match ? POS_W'(row) : '0;
      hold.col   <= match ? POS_W'(colp - NCW'(1)) : '0;
    end
    if (state == S_DONE && (!res_valid || res_ready)) begin
      res <= hold;
    end
  end

endmodule
